[rtl/assert_macros.svh]
// Assertion macros for the checker file of the pulse mapper.
// Every property is clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define MCPM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must be followed by another one on the next clock edge
`define MCPM_ASSERT_NEXT(label, ante, cons, msg) \
	`MCPM_ASSERT(label, (ante) |=> (cons), msg)

`endif

[rtl/mcpm_pkg.sv]
`timescale 1ns / 1ps
// Package for the motor command to pulse mapper: widths, codes, reset values
// and the pulse clamp helper. No dependencies.
package mcpm_pkg;

	// Field and datapath widths
	localparam int PW   = 12;      // pulse width in microseconds
	localparam int OW   = 16;      // command value, offset, position
	localparam int DBW  = 10;      // deadband
	localparam int SW   = 11;      // span
	localparam int CW   = 18;      // effective center (center + offset)
	localparam int DW   = 19;      // pulse differences
	localparam int MAW  = 12;      // multiplier operand A
	localparam int PRW  = MAW + DW; // multiplier product
	localparam int NW   = 26;      // dividend magnitude, also divider step count
	localparam int QW   = 16;      // divisor magnitude
	localparam int XW   = 28;      // wide sums ahead of clamp or saturation
	localparam int CNTW = 5;       // divider step counter
	localparam int RIW  = 3;       // register index

	// Arithmetic constants
	localparam logic signed [OW-1:0]  RAW_MIN     = 16'sd544;
	localparam logic signed [MAW-1:0] FULL_SCALE  = 12'sd100;
	localparam logic [QW-1:0]         MAP_DIVISOR = 16'd100;
	localparam logic signed [XW-1:0]  READ_BIAS   = -28'sd100;
	localparam logic signed [XW-1:0]  POS_MAX     = 28'sd32767;
	localparam logic signed [XW-1:0]  POS_MIN     = -28'sd32768;

	// Register reset values
	localparam logic [PW-1:0]         PULSE_MIN_RST    = 12'd1000;
	localparam logic [PW-1:0]         PULSE_MAX_RST    = 12'd2000;
	localparam logic [PW-1:0]         PULSE_CENTER_RST = 12'd1500;
	localparam logic [DBW-1:0]        DEADBAND_RST     = 10'd0;
	localparam logic signed [SW-1:0]  SPAN_RST         = 11'sd100;

	typedef enum logic [1:0] {
		CMD_WRITE     = 2'd0,
		CMD_CALIBRATE = 2'd1,
		CMD_STOP      = 2'd2
	} cmd_t;

	typedef enum logic [RIW-1:0] {
		REG_PULSE_MIN    = 3'd0,
		REG_PULSE_MAX    = 3'd1,
		REG_PULSE_CENTER = 3'd2,
		REG_DEADBAND     = 3'd3,
		REG_SPAN         = 3'd4
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MAP_MUL,
		ST_MAP_DIV,
		ST_MAP_FIN,
		ST_READ_SETUP,
		ST_READ_MUL,
		ST_READ_DIV,
		ST_READ_FIN,
		ST_DONE
	} state_t;

	// Clamp a wide signed value to pmin..pmax; lower bound checked first
	function automatic logic [PW-1:0] clamp_pulse(input logic signed [XW-1:0] x,
			input logic [PW-1:0] pmin, input logic [PW-1:0] pmax);
		logic signed [XW-1:0] lo;
		logic signed [XW-1:0] hi;
		lo = $signed({{(XW-PW){1'b0}}, pmin});
		hi = $signed({{(XW-PW){1'b0}}, pmax});
		if (x < lo) begin
			return pmin;
		end else if (x > hi) begin
			return pmax;
		end else begin
			return x[PW-1:0];
		end
	endfunction

endpackage

[rtl/motor_command_to_pulse_mapper.sv]
`timescale 1ns / 1ps
// Motor command to pulse mapper: one transaction at a time through a shared
// multiplier and a 26-step restoring divider (one quotient bit per cycle).
// Mapped writes run map multiply, divide and finish, then read-back; every command reads
// back, skipping its multiply and divide when the read-back divisor is zero. Input stalls
// until the result is loaded, and a stalled earlier result holds off that load.
// Async active-low reset: registers to defaults, pulse/offset zero. Uses mcpm_pkg.
module motor_command_to_pulse_mapper (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_wr_en,
	input  logic [mcpm_pkg::RIW-1:0]          cfg_index,
	input  logic [mcpm_pkg::PW-1:0]           cfg_wdata,
	// command channel
	input  logic                              cmd_valid,
	output logic                              cmd_stall,
	input  logic [1:0]                        cmd,
	input  logic signed [mcpm_pkg::OW-1:0]    value,
	// result channel
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [mcpm_pkg::PW-1:0]           pulse_width,
	output logic signed [mcpm_pkg::OW-1:0]    position
);

	localparam int PW   = mcpm_pkg::PW;
	localparam int OW   = mcpm_pkg::OW;
	localparam int DBW  = mcpm_pkg::DBW;
	localparam int SW   = mcpm_pkg::SW;
	localparam int CW   = mcpm_pkg::CW;
	localparam int DW   = mcpm_pkg::DW;
	localparam int MAW  = mcpm_pkg::MAW;
	localparam int PRW  = mcpm_pkg::PRW;
	localparam int NW   = mcpm_pkg::NW;
	localparam int QW   = mcpm_pkg::QW;
	localparam int XW   = mcpm_pkg::XW;
	localparam int CNTW = mcpm_pkg::CNTW;

	// configuration registers
	logic [PW-1:0]          pmin_q, pmax_q, pctr_q;
	logic [DBW-1:0]         dband_q;
	logic signed [SW-1:0]   span_q;

	// block state
	logic [PW-1:0]          pulse_q;
	logic signed [OW-1:0]   offset_q;
	logic signed [OW-1:0]   pos_q;

	// captured transaction
	logic [1:0]             cmd_q;
	logic signed [OW-1:0]   value_q;

	// sequencer
	mcpm_pkg::state_t       state_q, state_d;
	logic                   res_load;
	logic                   res_free;
	logic                   div_last;

	// shared multiplier and divider
	logic signed [MAW-1:0]  mul_a_q;
	logic signed [DW-1:0]   mul_b_q;
	logic signed [XW-1:0]   base_q;
	logic [QW-1:0]          dvs_q;
	logic                   dvs_neg_q;
	logic [NW-1:0]          quo_q;
	logic [QW-1:0]          rem_q;
	logic                   neg_q;
	logic [CNTW-1:0]        cnt_q;

	// result register
	logic                   res_valid_q;
	logic [PW-1:0]          res_pulse_q;
	logic signed [OW-1:0]   res_pos_q;

	// effective center and extended bounds
	logic signed [CW-1:0]   ctr_eff;
	logic signed [DW-1:0]   c19, pmin19, pmax19;

	// write mapping
	logic                   span_neg;
	logic signed [MAW-1:0]  span_x, lim;
	logic signed [OW:0]     val17, lim17, vcl17;
	logic signed [MAW-1:0]  vcl, vmag, vdb, vsg;
	logic                   map_low;
	logic                   raw_write;
	logic signed [MAW-1:0]  map_a;
	logic signed [DW-1:0]   map_b;
	logic signed [XW-1:0]   map_base;

	// calibration
	logic signed [OW:0]     osum;
	logic signed [OW-1:0]   osat;

	// read-back setup
	logic signed [DW-1:0]   p19, rd_d, rd_n, rd_dmag;
	logic                   rd_low;

	// multiplier and divider step
	logic signed [PRW-1:0]  prod, prod_mag;
	logic [QW:0]            rem_sh, rem_sub;
	logic                   step_ge;
	logic [QW-1:0]          rem_nx;
	logic [NW-1:0]          quo_nx;
	logic signed [NW:0]     quo_s;
	logic signed [XW-1:0]   fin_sum, rd_r;
	logic signed [OW-1:0]   rd_sat;

	// Effective center (sign-extended) and zero-extended bounds
	assign ctr_eff = $signed({{(CW-PW){1'b0}}, pctr_q})
		+ $signed({{(CW-OW){offset_q[OW-1]}}, offset_q});
	assign c19     = $signed({{(DW-CW){ctr_eff[CW-1]}}, ctr_eff});
	assign pmin19  = $signed({{(DW-PW){1'b0}}, pmin_q});
	assign pmax19  = $signed({{(DW-PW){1'b0}}, pmax_q});

	// Percent command: clamp to +-|span|, apply deadband, invert on negative span
	always_comb begin
		span_neg = span_q[SW-1];
		span_x   = $signed({span_q[SW-1], span_q});
		lim      = span_neg ? -span_x : span_x;
		val17    = $signed({value_q[OW-1], value_q});
		lim17    = $signed({{(OW+1-MAW){lim[MAW-1]}}, lim});
		if (val17 < -lim17) begin
			vcl17 = -lim17;
		end else if (val17 > lim17) begin
			vcl17 = lim17;
		end else begin
			vcl17 = val17;
		end
		vcl  = vcl17[MAW-1:0];
		vmag = vcl[MAW-1] ? -vcl : vcl;
		if ($unsigned(vmag) <= {{(MAW-DBW){1'b0}}, dband_q}) begin
			vdb = '0;
		end else begin
			vdb = vcl;
		end
		vsg       = span_neg ? -vdb : vdb;
		map_low   = vsg[MAW-1] || (vsg == '0);
		map_a     = map_low ? (vsg + mcpm_pkg::FULL_SCALE) : vsg;
		map_b     = map_low ? (c19 - pmin19) : (pmax19 - c19);
		map_base  = map_low ? $signed({{(XW-PW){1'b0}}, pmin_q})
			: $signed({{(XW-CW){ctr_eff[CW-1]}}, ctr_eff});
		raw_write = (value_q >= mcpm_pkg::RAW_MIN);
	end

	// Saturating offset add
	always_comb begin
		osum = $signed({offset_q[OW-1], offset_q}) + $signed({value_q[OW-1], value_q});
		if (osum[OW] != osum[OW-1]) begin
			osat = osum[OW] ? $signed({1'b1, {(OW-1){1'b0}}}) : $signed({1'b0, {(OW-1){1'b1}}});
		end else begin
			osat = osum[OW-1:0];
		end
	end

	// Read-back operands from the stored pulse
	always_comb begin
		p19     = $signed({{(DW-PW){1'b0}}, pulse_q}) + $signed({{(DW-1){1'b0}}, 1'b1});
		rd_low  = (p19 <= c19);
		rd_d    = rd_low ? (c19 - pmin19) : (pmax19 - c19);
		rd_n    = rd_low ? (p19 - pmin19) : (p19 - c19);
		rd_dmag = rd_d[DW-1] ? -rd_d : rd_d;
	end

	// Shared multiplier and one restoring divider step
	always_comb begin
		prod     = mul_a_q * mul_b_q;
		prod_mag = prod[PRW-1] ? -prod : prod;
		rem_sh   = {rem_q, quo_q[NW-1]};
		rem_sub  = rem_sh - {1'b0, dvs_q};
		step_ge  = (rem_sh >= {1'b0, dvs_q});
		rem_nx   = step_ge ? rem_sub[QW-1:0] : rem_sh[QW-1:0];
		quo_nx   = {quo_q[NW-2:0], step_ge};
	end

	// Signed quotient plus bias; read-back sign and saturation
	always_comb begin
		quo_s   = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		fin_sum = $signed({{(XW-NW-1){quo_s[NW]}}, quo_s}) + base_q;
		rd_r    = span_neg ? -fin_sum : fin_sum;
		if (rd_r > mcpm_pkg::POS_MAX) begin
			rd_sat = mcpm_pkg::POS_MAX[OW-1:0];
		end else if (rd_r < mcpm_pkg::POS_MIN) begin
			rd_sat = mcpm_pkg::POS_MIN[OW-1:0];
		end else begin
			rd_sat = rd_r[OW-1:0];
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcpm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshake outputs
	always_comb begin
		state_d   = state_q;
		res_free  = !res_valid_q || !res_stall;
		div_last  = (cnt_q == CNTW'(1));
		res_load  = 1'b0;
		cmd_stall = (state_q != mcpm_pkg::ST_IDLE);
		case (state_q)
			mcpm_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					state_d = mcpm_pkg::ST_DECODE;
				end
			end
			mcpm_pkg::ST_DECODE: begin
				if ((cmd_q == mcpm_pkg::CMD_WRITE) && !raw_write) begin
					state_d = mcpm_pkg::ST_MAP_MUL;
				end else begin
					state_d = mcpm_pkg::ST_READ_SETUP;
				end
			end
			mcpm_pkg::ST_MAP_MUL:  state_d = mcpm_pkg::ST_MAP_DIV;
			mcpm_pkg::ST_MAP_DIV: begin
				if (div_last) begin
					state_d = mcpm_pkg::ST_MAP_FIN;
				end
			end
			mcpm_pkg::ST_MAP_FIN:  state_d = mcpm_pkg::ST_READ_SETUP;
			mcpm_pkg::ST_READ_SETUP: begin
				if (rd_d == '0) begin
					state_d = mcpm_pkg::ST_DONE;
				end else begin
					state_d = mcpm_pkg::ST_READ_MUL;
				end
			end
			mcpm_pkg::ST_READ_MUL: state_d = mcpm_pkg::ST_READ_DIV;
			mcpm_pkg::ST_READ_DIV: begin
				if (div_last) begin
					state_d = mcpm_pkg::ST_READ_FIN;
				end
			end
			mcpm_pkg::ST_READ_FIN: state_d = mcpm_pkg::ST_DONE;
			mcpm_pkg::ST_DONE: begin
				if (res_free) begin
					res_load = 1'b1;
					state_d  = mcpm_pkg::ST_IDLE;
				end
			end
			default: state_d = mcpm_pkg::ST_IDLE;
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pmin_q  <= mcpm_pkg::PULSE_MIN_RST;
			pmax_q  <= mcpm_pkg::PULSE_MAX_RST;
			pctr_q  <= mcpm_pkg::PULSE_CENTER_RST;
			dband_q <= mcpm_pkg::DEADBAND_RST;
			span_q  <= mcpm_pkg::SPAN_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				mcpm_pkg::REG_PULSE_MIN:    pmin_q  <= cfg_wdata;
				mcpm_pkg::REG_PULSE_MAX:    pmax_q  <= cfg_wdata;
				mcpm_pkg::REG_PULSE_CENTER: pctr_q  <= cfg_wdata;
				mcpm_pkg::REG_DEADBAND:     dband_q <= cfg_wdata[DBW-1:0];
				mcpm_pkg::REG_SPAN:         span_q  <= $signed(cfg_wdata[SW-1:0]);
				default: ;
			endcase
		end
	end

	// Stored pulse and calibration offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_q  <= '0;
			offset_q <= '0;
		end else begin
			case (state_q)
				mcpm_pkg::ST_DECODE: begin
					case (cmd_q)
						mcpm_pkg::CMD_WRITE: begin
							if (raw_write) begin
								pulse_q <= mcpm_pkg::clamp_pulse(
									$signed({{(XW-OW){value_q[OW-1]}}, value_q}),
									pmin_q, pmax_q);
							end
						end
						mcpm_pkg::CMD_CALIBRATE: offset_q <= osat;
						mcpm_pkg::CMD_STOP: begin
							pulse_q <= mcpm_pkg::clamp_pulse(
								$signed({{(XW-CW){ctr_eff[CW-1]}}, ctr_eff}),
								pmin_q, pmax_q);
						end
						default: ;
					endcase
				end
				mcpm_pkg::ST_MAP_FIN: pulse_q <= mcpm_pkg::clamp_pulse(fin_sum, pmin_q, pmax_q);
				default: ;
			endcase
		end
	end

	// Capture the transaction
	always_ff @(posedge clk) begin
		if ((state_q == mcpm_pkg::ST_IDLE) && cmd_valid) begin
			cmd_q   <= cmd;
			value_q <= value;
		end
	end

	// Divider step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (state_q)
				mcpm_pkg::ST_MAP_MUL,
				mcpm_pkg::ST_READ_MUL: cnt_q <= CNTW'(NW);
				mcpm_pkg::ST_MAP_DIV,
				mcpm_pkg::ST_READ_DIV: cnt_q <= cnt_q - CNTW'(1);
				default: ;
			endcase
		end
	end

	// Operand setup, multiply, divide and read-back result
	always_ff @(posedge clk) begin
		case (state_q)
			mcpm_pkg::ST_DECODE: begin
				mul_a_q   <= map_a;
				mul_b_q   <= map_b;
				base_q    <= map_base;
				dvs_q     <= mcpm_pkg::MAP_DIVISOR;
				dvs_neg_q <= 1'b0;
			end
			mcpm_pkg::ST_READ_SETUP: begin
				mul_a_q   <= mcpm_pkg::FULL_SCALE;
				mul_b_q   <= rd_n;
				base_q    <= rd_low ? mcpm_pkg::READ_BIAS : '0;
				dvs_q     <= rd_dmag[QW-1:0];
				dvs_neg_q <= rd_d[DW-1];
				if (rd_d == '0) begin
					pos_q <= '0;
				end
			end
			mcpm_pkg::ST_MAP_MUL,
			mcpm_pkg::ST_READ_MUL: begin
				quo_q <= prod_mag[NW-1:0];
				rem_q <= '0;
				neg_q <= prod[PRW-1] ^ dvs_neg_q;
			end
			mcpm_pkg::ST_MAP_DIV,
			mcpm_pkg::ST_READ_DIV: begin
				quo_q <= quo_nx;
				rem_q <= rem_nx;
			end
			mcpm_pkg::ST_READ_FIN: pos_q <= rd_sat;
			default: ;
		endcase
	end

	// Result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_pulse_q <= pulse_q;
			res_pos_q   <= pos_q;
		end
	end

	assign res_valid   = res_valid_q;
	assign pulse_width = res_pulse_q;
	assign position    = res_pos_q;

endmodule

[rtl/mcpm_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the motor command to pulse mapper, bound to the top.
// Depends on assert_macros.svh.
module mcpm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_valid,
	input logic                cmd_stall,
	input logic                res_valid,
	input logic                res_stall,
	input logic [11:0]         pulse_width,
	input logic signed [15:0]  position
);

`include "assert_macros.svh"

	// An accepted transaction occupies the block on the next cycle
	`MCPM_ASSERT_NEXT(a_accept_busy, cmd_valid && !cmd_stall, cmd_stall, "no stall after accept")

	// A stalled result keeps its valid and payload
	`MCPM_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(pulse_width) && $stable(position), "stalled result changed")

	// A result appears only after the block was working on a transaction
	`MCPM_ASSERT(a_res_from_work, $rose(res_valid) |-> $past(cmd_stall), "result without work")

endmodule

bind motor_command_to_pulse_mapper mcpm_checker u_mcpm_checker (.*);
